[hdl/assert_macros.svh]
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same check, but also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[hdl/tch_pkg.sv]
// ----------------------------------------------------------------------------
// tch_pkg
// Shared constants and helpers for the tilt compensated heading unit.
// ----------------------------------------------------------------------------
`default_nettype none
package tch_pkg;
  localparam int CordicStagesDef = 16;
  localparam int AngleFracBitsDef = 13;
  localparam int TabLen = 24;
  localparam int AW = 36;  // Q30 angles with headroom
  localparam int DW = 36;  // Q30 sin/cos datapath
  localparam logic signed [AW-1:0] Pi30 = 36'sd3373259426;
  localparam logic signed [AW-1:0] HalfPi30 = 36'sd1686629713;
  localparam logic signed [DW-1:0] Gain30 = 36'sd652032874;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      default: t = 32'h0;
    endcase
    return $signed({4'b0, t});
  endfunction
endpackage
`default_nettype wire

[hdl/tch_cordic_stage.sv]
// ----------------------------------------------------------------------------
// tch_cordic_stage
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none
module tch_cordic_stage #(
  parameter int Shift = 0,
  parameter bit Vectoring = 1'b0,
  parameter int W = 36
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic signed [W-1:0]              x_i,
  input  wire logic signed [W-1:0]              y_i,
  input  wire logic signed [tch_pkg::AW-1:0]    z_i,
  output logic signed [W-1:0]                   x_o,
  output logic signed [W-1:0]                   y_o,
  output logic signed [tch_pkg::AW-1:0]         z_o
);
  logic pos;
  logic signed [tch_pkg::AW-1:0] a;
  assign a = tch_pkg::atan_tab(Shift);
  // rotation: direction from residual angle; vectoring: from y sign
  assign pos = Vectoring ? y_i[W-1] : !z_i[tch_pkg::AW-1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (pos) begin
        x_o <= x_i - (y_i >>> Shift);
        y_o <= y_i + (x_i >>> Shift);
        z_o <= Vectoring ? z_i - a : z_i - a;
      end else begin
        x_o <= x_i + (y_i >>> Shift);
        y_o <= y_i - (x_i >>> Shift);
        z_o <= z_i + a;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/tilt_compensated_heading_unit.sv]
// ----------------------------------------------------------------------------
// tilt_compensated_heading_unit
// Tilt compensated magnetometer heading, fully pipelined CORDIC datapath.
// ----------------------------------------------------------------------------
// Pipeline: 2*N + 7 register stages, N = CORDIC_STAGES capped at 24.
// Throughput: one transaction per cycle; the pipeline advances whenever the
//   output register is empty or being drained (global stall on backpressure).
// Reset: rst_ni clears only the stage valid bits; payload is unreset.
`default_nettype none
`include "assert_macros.svh"
module tilt_compensated_heading_unit #(
  parameter int CORDIC_STAGES = tch_pkg::CordicStagesDef,
  parameter int ANGLE_FRAC_BITS = tch_pkg::AngleFracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [15:0] roll_angle_i,
  input  wire logic signed [15:0] pitch_angle_i,
  input  wire logic signed [15:0] mag_x_i,
  input  wire logic signed [15:0] mag_y_i,
  input  wire logic signed [15:0] mag_z_i,
  input  wire logic               sample_error_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic signed [15:0]      heading_o,
  output logic                    status_o
);
  localparam int N = (CORDIC_STAGES > tch_pkg::TabLen) ? tch_pkg::TabLen : CORDIC_STAGES;
  localparam int AW = tch_pkg::AW;
  localparam int DW = tch_pkg::DW;
  // vectoring datapath: |x|,|y| < 2^48, grows by gain 1.65 -> 52 bits
  localparam int VW = 52;
  // pipeline: 1 prep, N rot, mult1, mult2, sum, N vec(+prep), wrap;
  // the output register follows the last of these
  localparam int L = 2 * N + 6;

  logic adv;
  logic [L-1:0] v_q;
  assign adv = !valid_o || ready_i;
  assign ready_o = adv;

  // valid / error sideband shift line
  logic [L-1:0] e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[L-2:0], valid_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) e_q <= {e_q[L-2:0], sample_error_i};
  end

  // stage 0: range reduction into +-pi/2
  logic signed [AW-1:0] ra, pa, ra0_q, pa0_q;
  logic rn0_q, pn0_q;
  // field samples ride along until the second multiplier stage
  logic signed [15:0] mx_q [N+2], my_q [N+2], mz_q [N+2];
  assign ra = AW'(roll_angle_i) <<< (30 - ANGLE_FRAC_BITS);
  assign pa = AW'(pitch_angle_i) <<< (30 - ANGLE_FRAC_BITS);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn0_q <= (ra > tch_pkg::HalfPi30) || (ra < -tch_pkg::HalfPi30);
      pn0_q <= (pa > tch_pkg::HalfPi30) || (pa < -tch_pkg::HalfPi30);
      ra0_q <= (ra > tch_pkg::HalfPi30) ? ra - tch_pkg::Pi30 :
               (ra < -tch_pkg::HalfPi30) ? ra + tch_pkg::Pi30 : ra;
      pa0_q <= (pa > tch_pkg::HalfPi30) ? pa - tch_pkg::Pi30 :
               (pa < -tch_pkg::HalfPi30) ? pa + tch_pkg::Pi30 : pa;
      mx_q[0] <= mag_x_i; my_q[0] <= mag_y_i; mz_q[0] <= mag_z_i;
    end
  end
  for (genvar k = 1; k < N + 2; k++) begin : g_mag
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mx_q[k] <= mx_q[k-1]; my_q[k] <= my_q[k-1]; mz_q[k] <= mz_q[k-1];
      end
    end
  end

  // rotation CORDIC for roll and pitch
  logic signed [DW-1:0] rx [N+1], ry [N+1], px [N+1], py [N+1];
  logic signed [AW-1:0] rz [N+1], pz [N+1];
  logic [N:0] rn, pn;
  assign rx[0] = tch_pkg::Gain30; assign ry[0] = '0; assign rz[0] = ra0_q;
  assign px[0] = tch_pkg::Gain30; assign py[0] = '0; assign pz[0] = pa0_q;
  assign rn[0] = rn0_q; assign pn[0] = pn0_q;
  for (genvar i = 0; i < N; i++) begin : g_rot
    tch_cordic_stage #(.Shift(i), .Vectoring(1'b0), .W(DW)) u_r (
      .clk_i, .en_i(adv), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]));
    tch_cordic_stage #(.Shift(i), .Vectoring(1'b0), .W(DW)) u_p (
      .clk_i, .en_i(adv), .x_i(px[i]), .y_i(py[i]), .z_i(pz[i]),
      .x_o(px[i+1]), .y_o(py[i+1]), .z_o(pz[i+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin rn[i+1] <= rn[i]; pn[i+1] <= pn[i]; end
    end
  end
  logic signed [DW-1:0] cp, sp, ct, st;
  assign cp = rn[N] ? -rx[N] : rx[N];
  assign sp = rn[N] ? -ry[N] : ry[N];
  assign ct = pn[N] ? -px[N] : px[N];
  assign st = pn[N] ? -py[N] : py[N];

  // stage M1: trig products; sin/cos fit 32 bits signed
  localparam int S1 = N + 1;
  logic signed [31:0] cp32, sp32, ct32, st32;
  assign cp32 = 32'(cp);
  assign sp32 = 32'(sp);
  assign ct32 = 32'(ct);
  assign st32 = 32'(st);
  logic signed [63:0] ss_q, sc_q;
  logic signed [31:0] cp1_q, sp1_q, ct1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ss_q <= st32 * sp32;
      sc_q <= st32 * cp32;
      cp1_q <= cp32; sp1_q <= sp32; ct1_q <= ct32;
    end
  end
  // stage M2: products with field samples (16 x 32 and 16 x 34)
  logic signed [63:0] t1_q, t2_q, t3_q, t4_q, t5_q;
  logic signed [33:0] ssr, scr;
  assign ssr = 34'(ss_q >>> 30);
  assign scr = 34'(sc_q >>> 30);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q <= mx_q[S1] * ct1_q;
      t2_q <= my_q[S1] * ssr;
      t3_q <= mz_q[S1] * scr;
      t4_q <= my_q[S1] * cp1_q;
      t5_q <= mz_q[S1] * sp1_q;
    end
  end
  // stage S: sums, then quadrant pre-rotation
  logic signed [VW-1:0] xf_q, yf_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xf_q <= VW'(t1_q + t2_q + t3_q);
      yf_q <= VW'(t4_q - t5_q);
    end
  end
  logic signed [VW-1:0] vx [N+1], vy [N+1];
  logic signed [AW-1:0] vz [N+1];
  logic [N:0] vzero;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vzero[0] <= (xf_q == '0) && (yf_q == '0);
      vx[0] <= xf_q[VW-1] ? -xf_q : xf_q;
      vy[0] <= xf_q[VW-1] ? -yf_q : yf_q;
      vz[0] <= !xf_q[VW-1] ? '0 : (yf_q[VW-1] ? -tch_pkg::Pi30 : tch_pkg::Pi30);
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    tch_cordic_stage #(.Shift(i), .Vectoring(1'b1), .W(VW)) u_v (
      .clk_i, .en_i(adv), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1]));
    always_ff @(posedge clk_i) begin
      if (adv) vzero[i+1] <= vzero[i];
    end
  end
  // wrap stage
  logic signed [AW-1:0] zw_q, zs;
  assign zs = vzero[N] ? '0 : vz[N];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zw_q <= (zs > tch_pkg::Pi30) ? zs - (tch_pkg::Pi30 <<< 1) :
              (zs < -tch_pkg::Pi30) ? zs + (tch_pkg::Pi30 <<< 1) : zs;
    end
  end
  // output register: round half up
  logic signed [AW-1:0] hr;
  assign hr = (zw_q + (AW'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= v_q[L-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_o <= e_q[L-1];
      heading_o <= e_q[L-1] ? '0 : 16'(hr);
    end
  end

  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni, valid_o && !ready_i |=> valid_o && $stable(heading_o), "output changed under stall")
  `ASSERT_CLK(a_err_zero, clk_i, rst_ni, valid_o && status_o |-> heading_o == '0, "error result with nonzero heading")
  `ASSERT_CLK(a_rdy, clk_i, rst_ni, ready_o == (!valid_o || ready_i), "ready mismatch")
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading unit testbench
// Drives roll, pitch and magnetometer transactions into the heading unit with
// bursty sender and stalling receiver, predicts each heading with a bit-true
// CORDIC model and checks every result in order.
// ----------------------------------------------------------------------------

// Holds the expected headings in order and checks results against them.
class heading_scoreboard;
  typedef struct {
    logic signed [15:0] heading;
    logic               status;
  } heading_t;

  heading_t pending_q[$];
  int       n_errors;
  int       n_checked;

  function void note_input(logic signed [15:0] hdg, logic st);
    heading_t e;
    e.heading = hdg;
    e.status  = st;
    pending_q.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] hdg, logic st);
    heading_t e;
    if (pending_q.size() == 0) begin
      report_mismatch("result with nothing pending");
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    if (hdg !== e.heading)
      report_mismatch($sformatf("heading got %0d exp %0d", hdg, e.heading));
    if (st !== e.status)
      report_mismatch($sformatf("status got %0d exp %0d", st, e.status));
  endfunction

  function void report_mismatch(string msg);
    n_errors++;
    if (n_errors <= 40) $display("MISMATCH #%0d: %s", n_errors, msg);
  endfunction
endclass

module testbench;
  localparam int Stages    = tch_pkg::CordicStagesDef;
  localparam int FracBits  = tch_pkg::AngleFracBitsDef;
  localparam int Latency   = 2 * Stages + 7;
  localparam int NumRandom = 1600;
  localparam longint CycleLimit = 400000;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint GainQ30   = 64'sd652032874;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic signed [15:0] roll_angle_i = '0;
  logic signed [15:0] pitch_angle_i = '0;
  logic signed [15:0] mag_x_i = '0;
  logic signed [15:0] mag_y_i = '0;
  logic signed [15:0] mag_z_i = '0;
  logic sample_error_i = 1'b0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic signed [15:0] heading_o;
  logic status_o;

  heading_scoreboard sb = new();
  longint cycle_cnt = 0;
  bit     hold_off = 1'b0;   // long receiver stall requested by the stimulus
  int     n_sent = 0;

  tilt_compensated_heading_unit i_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .roll_angle_i, .pitch_angle_i, .mag_x_i, .mag_y_i, .mag_z_i,
    .sample_error_i, .valid_o, .ready_i, .heading_o, .status_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Table value for stage i, Q30.
  function automatic longint atan_step(int i);
    return longint'(tch_pkg::atan_tab(i));
  endfunction

  // Rotation-mode CORDIC: angle in input format -> cos, sin in Q30.
  // Angles past +-pi/2 are folded by pi and the outputs negated.
  function automatic void rotate_sincos(input logic signed [15:0] ang,
                                        output longint c, output longint s);
    longint a, x, y, nx;
    bit fold;
    a = longint'(ang) * (longint'(1) << (30 - FracBits));
    x = GainQ30;
    y = 0;
    fold = 1'b0;
    if (a > HalfPiQ30) begin
      a -= PiQ30; fold = 1'b1;
    end else if (a < -HalfPiQ30) begin
      a += PiQ30; fold = 1'b1;
    end
    for (int i = 0; i < Stages; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); a -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); a += atan_step(i);
      end
      x = nx;
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
  endfunction

  // Vectoring-mode CORDIC atan2 in Q30; left half plane mirrored through pi.
  function automatic longint vector_atan2(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PiQ30 : -PiQ30;
      x = -x; y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  // Tilt-compensated heading of one sample, rounded half up to output format.
  function automatic logic signed [15:0] predict_heading(
      logic signed [15:0] roll, logic signed [15:0] pitch,
      logic signed [15:0] mx, logic signed [15:0] my, logic signed [15:0] mz);
    longint cr, sr, cp, sp, hx, hy, z;
    rotate_sincos(roll, cr, sr);
    rotate_sincos(pitch, cp, sp);
    hx = longint'(mx) * cp + longint'(my) * ((sp * sr) >>> 30)
       + longint'(mz) * ((sp * cr) >>> 30);
    hy = longint'(my) * cr - longint'(mz) * sr;
    z = vector_atan2(hy, hx);
    if (z > PiQ30) z -= 2 * PiQ30;
    else if (z < -PiQ30) z += 2 * PiQ30;
    z = (z + (longint'(1) << (29 - FracBits))) >>> (30 - FracBits);
    return z[15:0];
  endfunction

  // Offer one transaction and hold it until accepted; records expectation.
  task automatic send_sample(logic signed [15:0] roll, logic signed [15:0] pitch,
                             logic signed [15:0] mx, logic signed [15:0] my,
                             logic signed [15:0] mz, logic err);
    roll_angle_i   <= roll;
    pitch_angle_i  <= pitch;
    mag_x_i        <= mx;
    mag_y_i        <= my;
    mag_z_i        <= mz;
    sample_error_i <= err;
    valid_i        <= 1'b1;
    do @(posedge clk_i); while (!ready_o);
    if (err) sb.note_input('0, 1'b1);
    else sb.note_input(predict_heading(roll, pitch, mx, my, mz), 1'b0);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Angle anywhere in the legal range, edges favored now and then.
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'sd25736;
      1: return -16'sd25736;
      2: return $urandom_range(0, 1) ? 16'sd12868 : -16'sd12868;
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_mag();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: stalls on its own pattern, plus the long hold-off on request.
  initial begin : receiver
    int mode;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) ready_i <= 1'b0;
      else begin
        mode = int'((cycle_cnt / 500) % 3);   // phases: always ready, light, heavy
        case (mode)
          0: ready_i <= 1'b1;
          1: ready_i <= ($urandom_range(0, 3) != 0);
          default: ready_i <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Results are sampled on the rising edge where the handshake completes.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) sb.check_result(heading_o, status_o);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** tilt_compensated_heading_unit: FAILED **");
      $finish;
    end
  end

  // Stimulus.
  initial begin : stimulus
    int burst;
    int drain;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, quadrant boundaries, zero vector, error flag.
    send_sample(0, 0, 16'sd1000, 0, 0, 1'b0);            // heading zero
    send_sample(0, 0, 0, 16'sd1000, 0, 1'b0);            // +pi/2
    send_sample(0, 0, -16'sd1000, 0, 0, 1'b0);           // x<0, y=0: pi
    send_sample(0, 0, -16'sd1000, -16'sd1, 0, 1'b0);     // x<0, y<0: -pi side
    send_sample(0, 0, 0, -16'sd1000, 0, 1'b0);
    send_sample(0, 0, 0, 0, 0, 1'b0);                    // zero vector
    send_sample(16'sd25736, -16'sd25736, 0, 0, 0, 1'b0); // zero field, tilted
    send_sample(16'sd25736, 16'sd25736, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(-16'sd25736, -16'sd25736, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sd12868, 16'sd12869, 16'sd300, -16'sd200, 16'sd900, 1'b0);
    send_sample(-16'sd12869, -16'sd12868, -16'sd300, 16'sd200, -16'sd900, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd5, 16'sd7, -16'sd3, 1'b0); // full span
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0001, 1'b0);
    send_sample(16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
    send_sample(16'sd1234, 16'sd777, 16'sd100, 16'sd100, 16'sd100, 1'b1);
    send_sample(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1);
    send_sample(0, 0, 0, 0, 0, 1'b1);

    // Pressure: receiver holds off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (Latency * 3) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (Latency + 30)
        send_sample(rand_angle(), rand_angle(), rand_mag(), rand_mag(), rand_mag(),
                    ($urandom_range(0, 9) == 0));
    join

    // Random bursts with random gaps; some stretches back to back.
    while (n_sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      repeat (burst)
        send_sample(rand_angle(), rand_angle(), rand_mag(), rand_mag(), rand_mag(),
                    ($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    valid_i <= 1'b0;

    // Drain.
    drain = 0;
    while (sb.pending_q.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (Latency + 10) @(posedge clk_i);

    $display("Sent %0d samples (with error flags, tilt extremes, all quadrants),",
             n_sent);
    $display("checked %0d headings, %0d left pending, including a long output stall.",
             sb.n_checked, sb.pending_q.size());
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("** tilt_compensated_heading_unit: PASSED **");
    end else begin
      $display("** tilt_compensated_heading_unit: FAILED **");
    end
    $finish;
  end
endmodule
